[design/v3au_pkg.sv]
// v3au_pkg: shared types, constants and helpers of the 3d vector arithmetic unit
// no dependencies; imported by every module of the block

package v3au_pkg;

  localparam int WORD_BITS   = 32;
  localparam int FRAC_BITS   = 16;
  localparam int TOL_BITS    = 16;
  localparam int LANES       = 3;
  localparam int DIST_LANES  = 2;
  localparam int PROD_BITS   = 2 * WORD_BITS + 2;
  localparam int RAD_BITS    = 2 * WORD_BITS;
  localparam int ROOT_BITS   = WORD_BITS;
  localparam int NUM_BITS    = WORD_BITS + FRAC_BITS;
  localparam int SQRT_STAGES = ROOT_BITS;
  localparam int DIV_STAGES  = NUM_BITS;
  localparam int LATENCY     = SQRT_STAGES + DIV_STAGES + 4;
  localparam int ADDR_BITS   = 3;
  localparam int APB_BITS    = 32;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_EQUAL  = 4'd4,
    OP_DIST   = 4'd5,
    OP_LENGTH = 4'd6,
    OP_DOT    = 4'd7,
    OP_CROSS  = 4'd8,
    OP_NORM   = 4'd9
  } op_t;

  typedef struct packed {
    logic [3:0] operation;
    word_t      a_x;
    word_t      a_y;
    word_t      a_z;
    word_t      b_x;
    word_t      b_y;
    word_t      b_z;
  } item_t;

  typedef struct packed {
    word_t r_x;
    word_t r_y;
    word_t r_z;
    word_t r_scalar;
    logic  is_equal;
    logic  overflowed;
    logic  divide_by_zero;
  } result_t;

  // merge stage output: scalar dot product, radicand and equality
  typedef struct packed {
    word_t               dot;
    logic                dot_ov;
    logic [RAD_BITS-1:0] rad;
    logic                rad_big;
    logic                eq;
  } mrg_t;

  // side data that rides along the root pipeline
  typedef struct packed {
    logic [3:0]        operation;
    word_t [LANES-1:0] a;
    word_t [LANES-1:0] b;
    word_t [LANES-1:0] vec;
    logic              vec_ov;
    word_t             dot;
    logic              dot_ov;
    logic              rad_big;
    logic              eq;
  } pre_t;

  // side data that rides along the divider pipeline
  typedef struct packed {
    logic              use_div;
    word_t [LANES-1:0] vec;
    word_t [LANES-1:0] spec;
    logic [LANES-1:0]  neg;
    logic [LANES-1:0]  zden;
    word_t             scalar;
    logic              ov;
    logic              eq;
    logic              dz;
  } post_t;

  function automatic word_t sat_prod(input prod_t v);
    if (v > prod_t'(WORD_MAX)) return WORD_MAX;
    if (v < prod_t'(WORD_MIN)) return WORD_MIN;
    return word_t'(v);
  endfunction

  function automatic logic ovf_prod(input prod_t v);
    return (v > prod_t'(WORD_MAX)) || (v < prod_t'(WORD_MIN));
  endfunction

  function automatic logic [WORD_BITS-1:0] mag_word(input word_t v);
    return v[WORD_BITS-1] ? WORD_BITS'(-v) : WORD_BITS'(v);
  endfunction

endpackage

[design/v3au_lane.sv]
// v3au_lane: one vector component lane, multipliers and componentwise results
// depends on v3au_pkg

module v3au_lane (
  input  logic                          clk,
  input  logic [3:0]                    operation,
  input  v3au_pkg::word_t               a_i,
  input  v3au_pkg::word_t               a_j,
  input  v3au_pkg::word_t               a_k,
  input  v3au_pkg::word_t               b_i,
  input  v3au_pkg::word_t               b_j,
  input  v3au_pkg::word_t               b_k,
  input  logic                          dist_en,
  input  logic [v3au_pkg::TOL_BITS-1:0] tol,
  output v3au_pkg::prod_t               prod,
  output logic                          near,
  output v3au_pkg::word_t               res,
  output logic                          res_ov
);
  import v3au_pkg::*;

  localparam int OPND_BITS = WORD_BITS + 1;
  typedef logic signed [OPND_BITS-1:0] opnd_t;

  opnd_t                sum_n, dif_n, d, x, y;
  opnd_t                sum_q, dif_q;
  logic [OPND_BITS-1:0] mag_d;
  prod_t                m1, m2, prod2, cross_n, v;
  logic [3:0]           op_q;

  always_comb begin
    sum_n = opnd_t'(a_i) + opnd_t'(b_i);
    dif_n = opnd_t'(a_i) - opnd_t'(b_i);
    d     = opnd_t'(b_i) - opnd_t'(a_i);
    mag_d = dif_n[OPND_BITS-1] ? OPND_BITS'(-dif_n) : OPND_BITS'(dif_n);
    case (operation)
      OP_CROSS: begin
        x = opnd_t'(a_j);
        y = opnd_t'(b_k);
      end
      OP_LENGTH, OP_NORM: begin
        x = opnd_t'(a_i);
        y = opnd_t'(a_i);
      end
      OP_DIST: begin
        x = dist_en ? d : '0;
        y = dist_en ? d : '0;
      end
      default: begin
        x = opnd_t'(a_i);
        y = opnd_t'(b_i);
      end
    endcase
    m1 = prod_t'(x) * prod_t'(y);
    m2 = prod_t'(a_k) * prod_t'(b_j);
  end

  always_ff @(posedge clk) begin
    prod  <= m1;
    prod2 <= m2;
    near  <= mag_d < OPND_BITS'(tol);
    sum_q <= sum_n;
    dif_q <= dif_n;
    op_q  <= operation;
  end

  always_comb begin
    cross_n = prod - prod2;
    case (op_q)
      OP_ADD:   v = prod_t'(sum_q);
      OP_SUB:   v = prod_t'(dif_q);
      OP_MUL:   v = prod >>> FRAC_BITS;
      OP_CROSS: v = cross_n >>> FRAC_BITS;
      default:  v = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    res    <= sat_prod(v);
    res_ov <= ovf_prod(v);
  end

endmodule

[design/v3au_merge.sv]
// v3au_merge: combines the lane products into dot product, radicand and equality
// depends on v3au_pkg

module v3au_merge (
  input  logic            clk,
  input  logic [3:0]      operation,
  input  v3au_pkg::prod_t prod_x,
  input  v3au_pkg::prod_t prod_y,
  input  v3au_pkg::prod_t prod_z,
  input  logic            near_x,
  input  logic            near_y,
  input  logic            near_z,
  output v3au_pkg::mrg_t  mrg
);
  import v3au_pkg::*;

  localparam int SUM_BITS = PROD_BITS + 2;
  typedef logic signed [SUM_BITS-1:0] sum_t;

  sum_t  total, dot_sh;
  prod_t dot_p;

  always_comb begin
    total  = sum_t'(prod_x) + sum_t'(prod_y) + sum_t'(prod_z);
    dot_sh = total >>> FRAC_BITS;
    dot_p  = prod_t'(dot_sh);
  end

  always_ff @(posedge clk) begin
    mrg.dot     <= sat_prod(dot_p);
    mrg.dot_ov  <= ovf_prod(dot_p);
    mrg.rad     <= total[RAD_BITS-1:0];
    mrg.rad_big <= |total[SUM_BITS-1:RAD_BITS];
    mrg.eq      <= (operation == OP_EQUAL) && near_x && near_y && near_z;
  end

endmodule

[design/v3au_sqrt.sv]
// v3au_sqrt: pipelined floor square root, one result bit per stage
// depends on v3au_pkg

module v3au_sqrt (
  input  logic                           clk,
  input  logic [v3au_pkg::RAD_BITS-1:0]  rad,
  output logic [v3au_pkg::ROOT_BITS-1:0] root
);
  import v3au_pkg::*;

  localparam int REM_BITS = ROOT_BITS + 2;

  logic [REM_BITS-1:0]  rem_q  [SQRT_STAGES];
  logic [ROOT_BITS-1:0] root_q [SQRT_STAGES];
  logic [RAD_BITS-1:0]  rest_q [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    logic [REM_BITS-1:0]  rem_in;
    logic [ROOT_BITS-1:0] root_in;
    logic [RAD_BITS-1:0]  rest_in;
    logic [REM_BITS+1:0]  cand, trial;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rest_in = rad;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rest_in = rest_q[s-1];
    end

    assign cand  = {rem_in, rest_in[RAD_BITS-1 -: 2]};
    assign trial = (REM_BITS+2)'({root_in, 2'b01});

    always_ff @(posedge clk) begin
      if (cand >= trial) begin
        rem_q[s]  <= REM_BITS'(cand - trial);
        root_q[s] <= {root_in[ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_q[s]  <= REM_BITS'(cand);
        root_q[s] <= {root_in[ROOT_BITS-2:0], 1'b0};
      end
      rest_q[s] <= {rest_in[RAD_BITS-3:0], 2'b00};
    end
  end

  assign root = root_q[SQRT_STAGES-1];

endmodule

[design/v3au_div.sv]
// v3au_div: pipelined unsigned restoring divider, one quotient bit per stage
// depends on v3au_pkg

module v3au_div (
  input  logic                          clk,
  input  logic [v3au_pkg::NUM_BITS-1:0]  num,
  input  logic [v3au_pkg::WORD_BITS-1:0] den,
  output logic [v3au_pkg::NUM_BITS-1:0]  quo
);
  import v3au_pkg::*;

  logic [WORD_BITS-1:0] rem_q  [DIV_STAGES];
  logic [WORD_BITS-1:0] den_q  [DIV_STAGES];
  logic [NUM_BITS-1:0]  rest_q [DIV_STAGES];
  logic [NUM_BITS-1:0]  quo_q  [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [WORD_BITS-1:0] rem_in, den_in;
    logic [NUM_BITS-1:0]  rest_in, quo_in;
    logic [WORD_BITS:0]   cand, den_x;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign den_in  = den;
      assign rest_in = num;
      assign quo_in  = '0;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign rest_in = rest_q[s-1];
      assign quo_in  = quo_q[s-1];
    end

    assign cand  = {rem_in, rest_in[NUM_BITS-1]};
    assign den_x = (WORD_BITS+1)'(den_in);

    always_ff @(posedge clk) begin
      if (cand >= den_x) begin
        rem_q[s] <= WORD_BITS'(cand - den_x);
        quo_q[s] <= {quo_in[NUM_BITS-2:0], 1'b1};
      end else begin
        rem_q[s] <= WORD_BITS'(cand);
        quo_q[s] <= {quo_in[NUM_BITS-2:0], 1'b0};
      end
      den_q[s]  <= den_in;
      rest_q[s] <= {rest_in[NUM_BITS-2:0], 1'b0};
    end
  end

  assign quo = quo_q[DIV_STAGES-1];

endmodule

[design/vector3_arithmetic_unit_core.sv]
// vector3_arithmetic_unit_core: top level of the 3d vector arithmetic unit
// depends on v3au_pkg, v3au_lane, v3au_merge, v3au_sqrt, v3au_div
//
//   channel   signals                               handshake
//   -------   -----------------------------------   ------------------------------
//   input     start, busy, operands (item_t)        taken when start & !busy
//   result    done, result (result_t)               one-cycle strobe, no back-pressure
//   config    psel penable pwrite paddr pwdata      apb read/write, pready always high
//             prdata pready
//
// one item per clock cycle, accepted when start is high
// the pipeline depth is set mostly by the 32-stage square root pipeline and the 48-stage divider
// busy stays low: every stage advances each cycle, so no item ever waits
// reset clears the valid chain, done and the tolerance register (back to 7)
// the receiver cannot stall; results leave in the order the items came in

module vector3_arithmetic_unit_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  v3au_pkg::item_t                operands,
  output logic                           done,
  output v3au_pkg::result_t              result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [v3au_pkg::ADDR_BITS-1:0] paddr,
  input  logic [v3au_pkg::APB_BITS-1:0]  pwdata,
  output logic [v3au_pkg::APB_BITS-1:0]  prdata,
  output logic                           pready
);
  import v3au_pkg::*;

  localparam int VLD_DEPTH = SQRT_STAGES + DIV_STAGES + 3;
  localparam logic [NUM_BITS-1:0] Q_POS_LIM = NUM_BITS'(WORD_MAX);
  localparam logic [NUM_BITS-1:0] Q_NEG_LIM = NUM_BITS'(WORD_MAX) + NUM_BITS'(1);

  logic [TOL_BITS-1:0]  tol;
  logic                 accept;
  logic [VLD_DEPTH-1:0] vld;

  item_t item_a, item_b, item_c;

  word_t [LANES-1:0] lane_a, lane_b;
  prod_t [LANES-1:0] lane_prod;
  logic  [LANES-1:0] lane_near;
  word_t [LANES-1:0] lane_res;
  logic  [LANES-1:0] lane_ov;

  mrg_t                 mrg;
  logic [ROOT_BITS-1:0] root;

  pre_t  pre_next;
  pre_t  pre_q [SQRT_STAGES];
  pre_t  pre;
  post_t post_next;
  post_t post_q [DIV_STAGES];
  post_t post;

  logic                 root_ov, div_op, norm_op;
  word_t                len;
  logic [NUM_BITS-1:0]  div_num [LANES];
  logic [WORD_BITS-1:0] div_den [LANES];
  logic [NUM_BITS-1:0]  div_quo [LANES];
  logic [NUM_BITS-1:0]  neg_quo [LANES];
  word_t [LANES-1:0]    fin_r;
  logic  [LANES-1:0]    fin_ov;
  result_t              result_next;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign prdata = paddr[ADDR_BITS-1] ? '0 : APB_BITS'(tol);

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_BITS'(7);
    end else if (psel && penable && pwrite && pready && !paddr[ADDR_BITS-1]) begin
      tol <= pwdata[TOL_BITS-1:0];
    end
  end

  // ---------------- input and valid chain ----------------
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[VLD_DEPTH-2:0], accept};
      done <= vld[VLD_DEPTH-1];
    end
  end

  // payload needs no reset, the valid chain qualifies it
  always_ff @(posedge clk) begin
    item_a <= operands;
    item_b <= item_a;
    item_c <= item_b;
  end

  always_comb begin
    lane_a[0] = item_a.a_x;
    lane_a[1] = item_a.a_y;
    lane_a[2] = item_a.a_z;
    lane_b[0] = item_a.b_x;
    lane_b[1] = item_a.b_y;
    lane_b[2] = item_a.b_z;
  end

  // ---------------- component lanes ----------------
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    v3au_lane u_lane (
      .clk       (clk),
      .operation (item_a.operation),
      .a_i       (lane_a[i]),
      .a_j       (lane_a[(i+1)%LANES]),
      .a_k       (lane_a[(i+2)%LANES]),
      .b_i       (lane_b[i]),
      .b_j       (lane_b[(i+1)%LANES]),
      .b_k       (lane_b[(i+2)%LANES]),
      .dist_en   (i < DIST_LANES),
      .tol       (tol),
      .prod      (lane_prod[i]),
      .near      (lane_near[i]),
      .res       (lane_res[i]),
      .res_ov    (lane_ov[i])
    );
  end

  // dot product sum, sum of squares and the equality verdict
  v3au_merge u_merge (
    .clk       (clk),
    .operation (item_b.operation),
    .prod_x    (lane_prod[0]),
    .prod_y    (lane_prod[1]),
    .prod_z    (lane_prod[2]),
    .near_x    (lane_near[0]),
    .near_y    (lane_near[1]),
    .near_z    (lane_near[2]),
    .mrg       (mrg)
  );

  v3au_sqrt u_sqrt (
    .clk  (clk),
    .rad  (mrg.rad),
    .root (root)
  );

  // side data delayed to line up with the root
  always_comb begin
    pre_next.operation = item_c.operation;
    pre_next.a[0]      = item_c.a_x;
    pre_next.a[1]      = item_c.a_y;
    pre_next.a[2]      = item_c.a_z;
    pre_next.b[0]      = item_c.b_x;
    pre_next.b[1]      = item_c.b_y;
    pre_next.b[2]      = item_c.b_z;
    pre_next.vec       = lane_res;
    pre_next.vec_ov    = |lane_ov;
    pre_next.dot       = mrg.dot;
    pre_next.dot_ov    = mrg.dot_ov;
    pre_next.rad_big   = mrg.rad_big;
    pre_next.eq        = mrg.eq;
  end

  always_ff @(posedge clk) begin
    pre_q[0] <= pre_next;
    for (int k = 1; k < SQRT_STAGES; k++) begin
      pre_q[k] <= pre_q[k-1];
    end
  end

  assign pre = pre_q[SQRT_STAGES-1];

  // ---------------- root out: scalar results, divider operands ----------------
  always_comb begin
    root_ov = pre.rad_big || root[ROOT_BITS-1];
    len     = root_ov ? WORD_MAX : word_t'(root);
    div_op  = (pre.operation == OP_DIV);
    norm_op = (pre.operation == OP_NORM);

    post_next.use_div = div_op || norm_op;
    post_next.vec     = pre.vec;
    post_next.eq      = pre.eq;
    post_next.dz      = 1'b0;

    case (pre.operation)
      OP_LENGTH, OP_DIST: begin
        post_next.scalar = len;
        post_next.ov     = root_ov;
      end
      OP_DOT: begin
        post_next.scalar = pre.dot;
        post_next.ov     = pre.dot_ov;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_CROSS: begin
        post_next.scalar = '0;
        post_next.ov     = pre.vec_ov;
      end
      default: begin
        post_next.scalar = '0;
        post_next.ov     = 1'b0;
      end
    endcase

    for (int i = 0; i < LANES; i++) begin
      div_num[i] = {mag_word(pre.a[i]), {FRAC_BITS{1'b0}}};
      div_den[i] = div_op ? mag_word(pre.b[i]) : WORD_BITS'(len);
      post_next.neg[i] = pre.a[i][WORD_BITS-1] ^ (div_op && pre.b[i][WORD_BITS-1]);
      if (div_op) begin
        post_next.zden[i] = (pre.b[i] == '0);
        // zero divisor: sign of the dividend picks the rail
        if (pre.a[i] > 0) begin
          post_next.spec[i] = WORD_MAX;
        end else if (pre.a[i] < 0) begin
          post_next.spec[i] = WORD_MIN;
        end else begin
          post_next.spec[i] = '0;
        end
      end else begin
        // zero-length normalize gives the zero vector
        post_next.zden[i] = (len == '0);
        post_next.spec[i] = '0;
      end
      if (div_op && pre.b[i] == '0) begin
        post_next.dz = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    post_q[0] <= post_next;
    for (int k = 1; k < DIV_STAGES; k++) begin
      post_q[k] <= post_q[k-1];
    end
  end

  assign post = post_q[DIV_STAGES-1];

  for (genvar i = 0; i < LANES; i++) begin : g_div
    v3au_div u_div (
      .clk (clk),
      .num (div_num[i]),
      .den (div_den[i]),
      .quo (div_quo[i])
    );
  end

  // ---------------- quotient sign, saturation and result assembly ----------------
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      neg_quo[i] = -div_quo[i];
      fin_r[i]   = post.vec[i];
      fin_ov[i]  = 1'b0;
      if (post.use_div) begin
        if (post.zden[i]) begin
          fin_r[i] = post.spec[i];
        end else if (post.neg[i]) begin
          if (div_quo[i] > Q_NEG_LIM) begin
            fin_r[i]  = WORD_MIN;
            fin_ov[i] = 1'b1;
          end else begin
            fin_r[i] = word_t'(neg_quo[i][WORD_BITS-1:0]);
          end
        end else begin
          if (div_quo[i] > Q_POS_LIM) begin
            fin_r[i]  = WORD_MAX;
            fin_ov[i] = 1'b1;
          end else begin
            fin_r[i] = word_t'(div_quo[i][WORD_BITS-1:0]);
          end
        end
      end
    end
    result_next.r_x            = fin_r[0];
    result_next.r_y            = fin_r[1];
    result_next.r_z            = fin_r[2];
    result_next.r_scalar       = post.scalar;
    result_next.is_equal       = post.eq;
    result_next.overflowed     = post.ov || (|fin_ov);
    result_next.divide_by_zero = post.dz;
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

[design/v3au_checker.sv]
// v3au_checker: port-level assertions for the 3d vector arithmetic unit
// depends on v3au_pkg; bound to vector3_arithmetic_unit_core

module v3au_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input v3au_pkg::item_t                operands,
  input logic                           done,
  input v3au_pkg::result_t              result,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [v3au_pkg::ADDR_BITS-1:0] paddr,
  input logic [v3au_pkg::APB_BITS-1:0]  pwdata,
  input logic [v3au_pkg::APB_BITS-1:0]  prdata,
  input logic                           pready
);
  import v3au_pkg::*;

  // every accepted item comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("item result missing after pipeline latency");

  // no result without an earlier accepted item to match it
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without matching item");

  // divide by zero only reported for a divide item
  a_dz_op: assert property (@(posedge clk) disable iff (rst)
    done && result.divide_by_zero |-> $past(operands.operation, LATENCY) == OP_DIV)
    else $error("divide by zero flag on a non-divide item");

  // an equality result carries no other outcome
  a_eq_clean: assert property (@(posedge clk) disable iff (rst)
    done && result.is_equal |->
      !result.overflowed && !result.divide_by_zero && result.r_scalar == '0)
    else $error("equality result mixed with other results");

  // tolerance register reads back what was written
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && !paddr[ADDR_BITS-1] |=>
      paddr[ADDR_BITS-1] || prdata == APB_BITS'($past(pwdata[TOL_BITS-1:0])))
    else $error("tolerance readback mismatch");

endmodule

bind vector3_arithmetic_unit_core v3au_checker u_checker (.*);
